FILE: rtl/mbec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbec_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FORE_COLOUR  = 3'd4;
  localparam logic [2:0] REG_BACK_COLOUR  = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // width used for screen coordinate compares, covers a 1024 pixel screen
  localparam int DIM_W = 11;

  // largest bitmap edge in pixels
  localparam logic [8:0] MAX_SIZE = 9'd256;

  // pixels in one bitmap word and the index of its leftmost bit
  localparam logic [8:0] BITS_PER_BYTE = 9'd8;
  localparam logic [2:0] TOP_BIT       = 3'd7;

  // one bitmap word with everything fixed for its pixels
  typedef struct packed {
    logic [7:0]  bits;        // pixel bits, msb leftmost
    logic [8:0]  x_base;      // screen column of the first pixel
    logic [13:0] row_base;    // y times screen width, wrapped
    logic        y_vis;       // the row lies on the screen
    logic [2:0]  last_k;      // index of the last pixel taken
    logic        last_image;  // the last pixel ends the bitmap
  } mbec_job_t;

endpackage

`default_nettype wire

FILE: rtl/mono_bitmap_expand_clip.sv
// Expands a 1 bit per pixel bitmap word into up to eight clipped RGB565 pixel writes.
// A word is held in the word register, then each pixel goes through the result register.
// Throughput: one pixel per cycle on the result side unless out_ready stalls it; a word
// gives one write for each pixel it covers, paced by the single result register.
// Reset (synchronous, active low) clears the counters and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module mono_bitmap_expand_clip #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [mbec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mbec_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_bitmap_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [13:0]                            out_pixel_address,
  output logic [15:0]                            out_pixel_colour,
  output logic                                   out_in_view,
  output logic                                   out_byte_done,
  output logic                                   out_image_done
);

  logic [7:0]  origin_x_r;
  logic [7:0]  origin_y_r;
  logic [8:0]  image_width_r;
  logic [8:0]  image_height_r;
  logic [15:0] fore_colour_r;
  logic [15:0] back_colour_r;
  logic [7:0]  column_count_r, column_count_nxt;
  logic [7:0]  row_count_r, row_count_nxt;

  logic [8:0]  w_eff;
  logic [8:0]  h_eff;
  logic        size_zero;
  logic [7:0]  col_n;
  logic [7:0]  row_n;
  logic [8:0]  remain;
  logic [8:0]  take;
  logic        end_row;
  logic        end_img;
  logic [8:0]  y_pos;
  logic [19:0] row_prod;
  logic        in_fire;
  logic        job_valid;
  logic        job_ready;
  mbec_pkg::mbec_job_t job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= 8'd0;
      origin_y_r     <= 8'd0;
      image_width_r  <= 9'd8;
      image_height_r <= 9'd8;
      fore_colour_r  <= 16'hFFFF;
      back_colour_r  <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_index)
        mbec_pkg::REG_ORIGIN_X:     origin_x_r     <= cfg_data[7:0];
        mbec_pkg::REG_ORIGIN_Y:     origin_y_r     <= cfg_data[7:0];
        mbec_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[8:0];
        mbec_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[8:0];
        mbec_pkg::REG_FORE_COLOUR:  fore_colour_r  <= cfg_data;
        mbec_pkg::REG_BACK_COLOUR:  back_colour_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes, fold stale counters back to zero
  always_comb begin
    w_eff     = (image_width_r  > mbec_pkg::MAX_SIZE) ? mbec_pkg::MAX_SIZE : image_width_r;
    h_eff     = (image_height_r > mbec_pkg::MAX_SIZE) ? mbec_pkg::MAX_SIZE : image_height_r;
    size_zero = (w_eff == 9'd0) || (h_eff == 9'd0);
    col_n     = ({1'b0, column_count_r} >= w_eff) ? 8'd0 : column_count_r;
    row_n     = ({1'b0, row_count_r} >= h_eff) ? 8'd0 : row_count_r;
    remain    = w_eff - {1'b0, col_n};
    end_row   = (remain <= mbec_pkg::BITS_PER_BYTE);
    take      = end_row ? remain : mbec_pkg::BITS_PER_BYTE;
    end_img   = end_row && (({1'b0, row_n} + 9'd1) == h_eff);
  end

  // word set-up: row base and flags for the pixel stage
  always_comb begin
    y_pos          = {1'b0, origin_y_r} + {1'b0, row_n};
    row_prod       = 20'(y_pos) * 20'(FB_WIDTH);
    job.bits       = in_bitmap_byte;
    job.x_base     = {1'b0, origin_x_r} + {1'b0, col_n};
    job.row_base   = row_prod[13:0];
    job.y_vis      = ({2'b00, y_pos} < mbec_pkg::DIM_W'(FB_HEIGHT));
    job.last_k     = take[2:0] - 3'd1;
    job.last_image = end_img;
  end

  assign in_ready  = job_ready;
  assign in_fire   = in_valid && in_ready;
  assign job_valid = in_fire && !size_zero;

  // position counters advance by the pixels a word covers at acceptance
  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (job_valid) begin
      if (end_row) begin
        column_count_nxt = 8'd0;
        row_count_nxt    = end_img ? 8'd0 : (row_n + 8'd1);
      end else begin
        column_count_nxt = col_n + take[7:0];
        row_count_nxt    = row_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= 8'd0;
      row_count_r    <= 8'd0;
    end else begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  mbec_pixel_gen #(
    .FB_WIDTH (FB_WIDTH)
  ) u_pixel_gen (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_valid),
    .job               (job),
    .job_ready         (job_ready),
    .fore_colour       (fore_colour_r),
    .back_colour       (back_colour_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_colour  (out_pixel_colour),
    .out_in_view       (out_in_view),
    .out_byte_done     (out_byte_done),
    .out_image_done    (out_image_done)
  );

endmodule

`default_nettype wire

FILE: rtl/mbec_pixel_gen.sv
`timescale 1ns / 1ps
`default_nettype none

module mbec_pixel_gen #(
  parameter int FB_WIDTH = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire mbec_pkg::mbec_job_t job,
  output logic                   job_ready,
  input  wire logic [15:0]       fore_colour,
  input  wire logic [15:0]       back_colour,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [13:0]            out_pixel_address,
  output logic [15:0]            out_pixel_colour,
  output logic                   out_in_view,
  output logic                   out_byte_done,
  output logic                   out_image_done
);

  logic                 busy_r, busy_nxt;
  mbec_pkg::mbec_job_t  job_r;
  logic [2:0]           k_r, k_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [13:0]          out_pixel_address_r;
  logic [15:0]          out_pixel_colour_r;
  logic                 out_in_view_r;
  logic                 out_byte_done_r;
  logic                 out_image_done_r;

  logic                 out_free;
  logic                 emit;
  logic                 last_pix;
  logic [9:0]           pix_x;
  logic                 pix_vis;
  logic                 pix_set;
  logic [13:0]          pix_addr;
  logic [15:0]          pix_colour;

  // stage control
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = busy_r && out_free;
  assign last_pix  = (k_r == job_r.last_k);
  assign job_ready = !busy_r || (emit && last_pix);

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (job_valid && job_ready) begin
      busy_nxt = 1'b1;
      k_nxt    = 3'd0;
    end else if (emit) begin
      if (last_pix) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  // current pixel
  always_comb begin
    pix_x      = {1'b0, job_r.x_base} + {7'd0, k_r};
    pix_vis    = job_r.y_vis &&
                 ({1'b0, pix_x} < mbec_pkg::DIM_W'(FB_WIDTH));
    pix_addr   = pix_vis ? (job_r.row_base + {4'd0, pix_x}) : 14'd0;
    pix_set    = job_r.bits[mbec_pkg::TOP_BIT - k_r];
    pix_colour = pix_set ? {fore_colour[7:0], fore_colour[15:8]}
                         : {back_colour[7:0], back_colour[15:8]};
  end

  // result register
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
    if (emit) begin
      out_pixel_address_r <= pix_addr;
      out_pixel_colour_r  <= pix_colour;
      out_in_view_r       <= pix_vis;
      out_byte_done_r     <= last_pix;
      out_image_done_r    <= last_pix && job_r.last_image;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_pixel_address_r;
  assign out_pixel_colour  = out_pixel_colour_r;
  assign out_in_view       = out_in_view_r;
  assign out_byte_done     = out_byte_done_r;
  assign out_image_done    = out_image_done_r;

  // checks
  a_job_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> job_ready)
    else $error("word handed over while the stage is busy");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r <= job_r.last_k))
    else $error("pixel index past the last pixel of the word");

  a_stay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !(emit && last_pix)) |=> busy_r)
    else $error("word dropped before its last pixel");

  a_image_done_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_image_done_r) |-> out_byte_done_r)
    else $error("image end not on the last pixel of a word");

  a_clip_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_view_r) |-> (out_pixel_address_r == 14'd0))
    else $error("clipped pixel carries an address");

endmodule

`default_nettype wire
